// ----- sv/bile_pkg.sv -----
package bile_pkg;

	// Field widths of one request and one response.
	localparam int VALUE_W  = 32;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD_HEAD = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_TAIL = 3'd1;
	localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd2;
	localparam logic [OP_W-1:0] OP_REM_TAIL = 3'd3;
	localparam logic [OP_W-1:0] OP_REM_VAL  = 3'd4;
	localparam logic [OP_W-1:0] OP_QUERY    = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] removed_value;
		logic                      found;
		logic [STATUS_W-1:0]       status;
		logic [COUNT_W-1:0]        count;
	} rsp_t;

endpackage

// ----- sv/bile_ram.sv -----
module bile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/bounded_int_list_engine_unit.sv -----
// Bounded list engine: one request per start beat, one response beat per done strobe.
// Inserts, spare op codes and requests on an empty list respond from the dispatch step, head or
// tail removal after a read step, and remove-value or query after scan steps and, for remove-value,
// shift steps, since one RAM port steps the search and the gap-closing shift one entry per cycle.
// busy drops with the strobe, so a new request can be taken while the done strobe is high.
// Reset clears the list to empty; the receiver cannot stall the response.
module bounded_int_list_engine_unit #(
	parameter int CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bile_pkg::req_t req,
	output logic           done,
	output bile_pkg::rsp_t rsp
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;

	logic [2:0]     st_q;
	bile_pkg::req_t req_q;
	bile_pkg::rsp_t rsp_q;
	logic           done_q;
	logic [IW-1:0]  front_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  idx_q;

	logic                         ram_we;
	logic [IW-1:0]                ram_waddr;
	logic [bile_pkg::VALUE_W-1:0] ram_wdata;
	logic [IW-1:0]                ram_raddr;
	logic [bile_pkg::VALUE_W-1:0] ram_rdata;

	logic          is_full;
	logic          is_empty;
	logic [IW-1:0] front_dec;
	logic          scan_last;
	logic          shift_last;
	logic          hit;

	// Physical position of the element at a given offset from the front.
	function automatic logic [IW-1:0] slot_f(input logic [IW-1:0] front,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(front) + (CW+1)'(off);
		if (sum >= (CW+1)'(CAPACITY)) begin
			sum = sum - (CW+1)'(CAPACITY);
		end
		return sum[IW-1:0];
	endfunction

	assign is_full    = (cnt_q == CW'(CAPACITY));
	assign is_empty   = (cnt_q == '0);
	assign front_dec  = (front_q == '0) ? IW'(CAPACITY - 1) : front_q - 1'b1;
	assign scan_last  = (idx_q + 1'b1 == cnt_q);
	assign shift_last = (idx_q + CW'(2) == cnt_q);
	assign hit        = (ram_rdata == req_q.value);

	bile_ram #(
		.WIDTH(bile_pkg::VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// RAM port control for each sequencer step.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_f(front_q, cnt_q);
		ram_wdata = req_q.value;
		ram_raddr = front_q;
		case (st_q)
			S_DISP: begin
				if ((req_q.op inside {bile_pkg::OP_ADD_HEAD, bile_pkg::OP_ADD_TAIL}) &&
						!is_full) begin
					ram_we = 1'b1;
					if (req_q.op == bile_pkg::OP_ADD_HEAD) begin
						ram_waddr = front_dec;
					end
				end
				if (req_q.op == bile_pkg::OP_REM_TAIL) begin
					ram_raddr = slot_f(front_q, cnt_q - 1'b1);
				end
			end
			S_SCAN: begin
				ram_raddr = slot_f(front_q, idx_q + 1'b1);
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = slot_f(front_q, idx_q);
				ram_wdata = ram_rdata;
				ram_raddr = slot_f(front_q, idx_q + CW'(2));
			end
			default: begin
			end
		endcase
	end

	// Sequencer: dispatch, read, scan and shift steps, then one response beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			done_q  <= 1'b0;
			front_q <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						st_q  <= S_DISP;
					end
				end
				S_DISP: begin
					rsp_q.removed_value <= '0;
					rsp_q.found         <= 1'b0;
					rsp_q.status        <= bile_pkg::ST_OK;
					rsp_q.count         <= bile_pkg::COUNT_W'(cnt_q);
					idx_q               <= '0;
					if (req_q.op inside {bile_pkg::OP_ADD_HEAD, bile_pkg::OP_ADD_TAIL}) begin
						if (is_full) begin
							rsp_q.status <= bile_pkg::ST_FULL;
						end else begin
							cnt_q       <= cnt_q + 1'b1;
							rsp_q.count <= bile_pkg::COUNT_W'(cnt_q + 1'b1);
							if (req_q.op == bile_pkg::OP_ADD_HEAD) begin
								front_q <= front_dec;
							end
						end
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end else if (req_q.op inside {bile_pkg::OP_REM_HEAD, bile_pkg::OP_REM_TAIL,
							bile_pkg::OP_REM_VAL, bile_pkg::OP_QUERY}) begin
						if (is_empty) begin
							rsp_q.status <= bile_pkg::ST_EMPTY;
							done_q       <= 1'b1;
							st_q         <= S_IDLE;
						end else if (req_q.op inside {bile_pkg::OP_REM_HEAD,
								bile_pkg::OP_REM_TAIL}) begin
							st_q <= S_RD;
						end else begin
							st_q <= S_SCAN;
						end
					end else begin
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end
				end
				S_RD: begin
					rsp_q.removed_value <= ram_rdata;
					rsp_q.count         <= bile_pkg::COUNT_W'(cnt_q - 1'b1);
					cnt_q               <= cnt_q - 1'b1;
					if (req_q.op == bile_pkg::OP_REM_HEAD) begin
						front_q <= slot_f(front_q, CW'(1));
					end
					done_q <= 1'b1;
					st_q   <= S_IDLE;
				end
				S_SCAN: begin
					if (hit) begin
						rsp_q.found <= 1'b1;
						if (req_q.op == bile_pkg::OP_QUERY || scan_last) begin
							if (req_q.op == bile_pkg::OP_REM_VAL) begin
								cnt_q       <= cnt_q - 1'b1;
								rsp_q.count <= bile_pkg::COUNT_W'(cnt_q - 1'b1);
							end
							done_q <= 1'b1;
							st_q   <= S_IDLE;
						end else begin
							st_q <= S_SHIFT;
						end
					end else if (scan_last) begin
						rsp_q.status <= bile_pkg::ST_MISSING;
						done_q       <= 1'b1;
						st_q         <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SHIFT: begin
					idx_q <= idx_q + 1'b1;
					if (shift_last) begin
						cnt_q       <= cnt_q - 1'b1;
						rsp_q.count <= bile_pkg::COUNT_W'(cnt_q - 1'b1);
						done_q      <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (st_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// A response beat only closes a request that was in progress.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q) != S_IDLE)
		else $error("response beat without a request in progress");

	// The held count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("held count above capacity");

	// An accepted request makes the block busy on the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// A found flag always comes with an ok status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.found) |-> rsp.status == bile_pkg::ST_OK)
		else $error("found flag with a failing status");

endmodule
